>>> rtl/pnq_pkg.sv
package pnq_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned INDEX_W = 4;
  // three squared 8-bit differences: max 3 * 255^2 = 195075
  localparam int unsigned DIST_W  = 18;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
  endfunction

endpackage

>>> rtl/pnq_if.sv
interface pnq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [pnq_pkg::INDEX_W-1:0]  entry_index;
  logic [pnq_pkg::COLOR_W-1:0]  entry_color;
  logic [pnq_pkg::CHAN_W-1:0]   red_in;
  logic [pnq_pkg::CHAN_W-1:0]   green_in;
  logic [pnq_pkg::CHAN_W-1:0]   blue_in;

  modport source (output valid, cmd, entry_index, entry_color, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, cmd, entry_index, entry_color, red_in, green_in, blue_in,
                  output ready);
endinterface

interface pnq_out_if;
  logic                       valid;
  logic                       ready;
  logic [pnq_pkg::CHAN_W-1:0] red_out;
  logic [pnq_pkg::CHAN_W-1:0] green_out;
  logic [pnq_pkg::CHAN_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

>>> rtl/palette_nearest_color_quantizer.sv
// Sequence: a load beat is written into the palette when accepted; with n = min(palette_count,
//   PALETTE_DEPTH) a pixel beat walks entries 0..n-1 through SCAN, DRAIN and FIN, one entry per
//   cycle on the single distance/compare unit (straight to FIN when n is 0). No new beat is taken
//   until FIN hands the result to the output register, which waits while out stalls.
// Reset: rst_ni async active low clears the sequencer, output valid and
//   palette_count; palette contents are undefined until loaded.
module palette_nearest_color_quantizer #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pnq_pkg::COUNT_W-1:0]   cfg_wdata_i,
  pnq_in_if.sink                        in_i,
  pnq_out_if.source                     out_o
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
  // compare width wide enough for both the register and the depth
  localparam int unsigned CMP_W = (CNT_W > pnq_pkg::COUNT_W) ? CNT_W : pnq_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;  // issue palette reads
  localparam logic [1:0] ST_DRAIN = 2'd2;  // compare the last entry read
  localparam logic [1:0] ST_FIN   = 2'd3;  // hand result to output reg

  logic [1:0] state_q, state_d;

  logic [pnq_pkg::COUNT_W-1:0] count_q;

  // palette memory, registered read
  logic [pnq_pkg::COLOR_W-1:0] mem_q [PALETTE_DEPTH];
  logic [pnq_pkg::COLOR_W-1:0] rdata_q;

  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             out_vld_q, out_vld_d;

  pnq_pkg::rgb_t               pix_q, pix_d;
  pnq_pkg::rgb_t               res_q, res_d;
  pnq_pkg::rgb_t               out_q, out_d;
  logic [pnq_pkg::DIST_W-1:0]  best_q, best_d;

  logic                        in_acc;
  logic                        load_we;
  logic [CNT_W-1:0]            n_eff;
  logic [pnq_pkg::DIST_W-1:0]  dist_sum;
  pnq_pkg::rgb_t               entry;
  logic                        last_rd;
  logic                        out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign load_we    = in_acc && (in_i.cmd == pnq_pkg::CMD_LOAD) &&
                      (CMP_W'(in_i.entry_index) < CMP_W'(PALETTE_DEPTH));

  // entries at or past the depth are never searched
  assign n_eff = (CMP_W'(count_q) > CMP_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                           : CNT_W'(count_q);

  // shared distance unit: one palette entry per cycle
  assign entry    = pnq_pkg::rgb_t'(rdata_q);
  assign dist_sum = pnq_pkg::DIST_W'(pnq_pkg::sq_diff(pix_q.red,   entry.red))
                  + pnq_pkg::DIST_W'(pnq_pkg::sq_diff(pix_q.green, entry.green))
                  + pnq_pkg::DIST_W'(pnq_pkg::sq_diff(pix_q.blue,  entry.blue));

  assign last_rd  = (CNT_W'(rd_idx_q) == (n_q - CNT_W'(1)));
  assign out_free = !out_vld_q || out_o.ready;

  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    n_d       = n_q;
    cmp_vld_d = 1'b0;
    pix_d     = pix_q;
    res_d     = res_q;
    best_d    = best_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    // strict less-than keeps the lower index on a tie
    if (cmp_vld_q && (dist_sum < best_q)) begin
      best_d = dist_sum;
      res_d  = entry;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.cmd == pnq_pkg::CMD_PIXEL)) begin
          pix_d    = '{red: in_i.red_in, green: in_i.green_in, blue: in_i.blue_in};
          res_d    = '{red: in_i.red_in, green: in_i.green_in, blue: in_i.blue_in};
          best_d   = '1;
          n_d      = n_eff;
          rd_idx_d = '0;
          state_d  = (n_eff == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b1;
        rd_idx_d  = rd_idx_q + IDX_W'(1);
        if (last_rd) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    n_q      <= n_d;
    pix_q    <= pix_d;
    res_q    <= res_d;
    best_q   <= best_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem_q[IDX_W'(in_i.entry_index)] <= in_i.entry_color;
    end
    rdata_q <= mem_q[rd_idx_q];
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.red_out   = out_q.red;
  assign out_o.green_out = out_q.green;
  assign out_o.blue_out  = out_q.blue;

  // result beat only ever appears out of the finish state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_FIN)
    else $error("output valid rose outside finish state");

  // the read pointer never passes the searched count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(rd_idx_q) < n_q))
    else $error("palette read past active count");

  // empty palette goes straight to finish (pixel passthrough)
  a_empty_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.cmd == pnq_pkg::CMD_PIXEL) && (n_eff == '0)) |=> (state_q == ST_FIN))
    else $error("empty palette did not bypass scan");

endmodule

>>> tb/sv/palette_nearest_color_quantizer_tb.sv
module palette_nearest_color_quantizer_tb;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned ITEMS_PER_SET = 103;
  localparam int unsigned NUM_SETS     = 10;
  // Settling margin after the last pending pixel before a register write.
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned MAX_REPORTS  = 10;

  // One input beat as the sender sees it; fields the command does not use
  // still carry random values so the block has to ignore them.
  typedef struct packed {
    logic                        cmd;
    logic [pnq_pkg::INDEX_W-1:0] idx;
    logic [pnq_pkg::COLOR_W-1:0] color;
    pnq_pkg::rgb_t               px;
  } quant_beat_t;

  // ------------------------------------------------------------------
  // Scoreboard: mirrors the palette and palette_count, predicts the
  // nearest color for every accepted pixel beat, checks results in order.
  // ------------------------------------------------------------------
  class quant_scoreboard;
    logic [pnq_pkg::COLOR_W-1:0] palette [DEPTH];
    logic [pnq_pkg::COUNT_W-1:0] count;
    pnq_pkg::rgb_t               nearest_q [$];
    int unsigned                 n_pixels, n_loads, n_checked, n_errors;

    static function int unsigned chan_dist(logic [pnq_pkg::CHAN_W-1:0] a,
                                           logic [pnq_pkg::CHAN_W-1:0] b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    function void note_input(quant_beat_t b);
      int unsigned   span, best, d_sum;
      pnq_pkg::rgb_t pick, ent;
      if (b.cmd == pnq_pkg::CMD_LOAD) begin
        palette[b.idx] = b.color;
        n_loads++;
        return;
      end
      // counts beyond the store depth saturate; an empty palette passes through
      span = (int'(count) > DEPTH) ? DEPTH : int'(count);
      pick = b.px;
      best = 32'hFFFF_FFFF;
      for (int i = 0; i < span; i++) begin
        ent   = palette[i];
        d_sum = chan_dist(b.px.red, ent.red) + chan_dist(b.px.green, ent.green) +
                chan_dist(b.px.blue, ent.blue);
        // strict compare: on a tie the lower index stays
        if (d_sum < best) begin
          best = d_sum;
          pick = ent;
        end
      end
      nearest_q.push_back(pick);
      n_pixels++;
    endfunction

    function void check(pnq_pkg::rgb_t got);
      pnq_pkg::rgb_t want;
      if (nearest_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: result %h with no pixel outstanding", got);
        return;
      end
      want = nearest_q.pop_front();
      n_checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: result %0d: red exp %h got %h, green exp %h got %h, blue exp %h got %h",
                   n_checked, want.red, got.red, want.green, got.green, want.blue, got.blue);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pnq_pkg::COUNT_W-1:0] cfg_wdata;

  pnq_in_if  in_if ();
  pnq_out_if out_if ();

  palette_nearest_color_quantizer #(.PALETTE_DEPTH(DEPTH)) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  quant_scoreboard sb = new();

  // Receiver knobs, set by the stimulus thread, consumed by the ready driver.
  bit          rx_free;       // keep ready high, no stalls
  int unsigned rx_hold;       // cycles of forced back-pressure still to apply
  bit          tx_gapless;
  int unsigned n_settings;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop well beyond the slowest legal run (max gaps, max stalls,
  // full palette searches on every pixel).
  initial begin
    #(12 * 800_000);
    $display("tb: failure");
    $finish;
  end

  // Result beats are checked at the rising edge; ready was set at the
  // preceding falling edge so it is stable here.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check('{red: out_if.red_out, green: out_if.green_out, blue: out_if.blue_out});
  end

  // Ready driver: random short stalls, rare long ones, plus a forced long
  // hold that the stimulus can request. One assignment per falling edge.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_if.ready = 1'b0;
        rx_hold--;
      end else if (rx_free) begin
        out_if.ready = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < 20) begin
        out_if.ready = 1'b0;
        stall_left = ($urandom_range(99) < 85) ? $urandom_range(2) : $urandom_range(59, 19);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (tx_gapless || roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic quant_beat_t mk_load(logic [pnq_pkg::INDEX_W-1:0] idx,
                                          logic [pnq_pkg::COLOR_W-1:0] color);
    quant_beat_t b;
    b.cmd   = pnq_pkg::CMD_LOAD;
    b.idx   = idx;
    b.color = color;
    b.px    = pnq_pkg::COLOR_W'($urandom());
    return b;
  endfunction

  function automatic quant_beat_t mk_pixel(pnq_pkg::rgb_t px);
    quant_beat_t b;
    b.cmd   = pnq_pkg::CMD_PIXEL;
    b.idx   = pnq_pkg::INDEX_W'($urandom());
    b.color = pnq_pkg::COLOR_W'($urandom());
    b.px    = px;
    return b;
  endfunction

  function automatic logic [pnq_pkg::CHAN_W-1:0] nudge(logic [pnq_pkg::CHAN_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    return (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : v[pnq_pkg::CHAN_W-1:0];
  endfunction

  // Random beat. Pixels cluster around palette entries and midpoints
  // between two entries, so near-ties and exact ties come up often.
  function automatic quant_beat_t random_beat();
    pnq_pkg::rgb_t a, b, px;
    a = sb.palette[$urandom_range(DEPTH - 1)];
    b = sb.palette[$urandom_range(DEPTH - 1)];
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0, 1: px = pnq_pkg::COLOR_W'($urandom());
        2:    px = a;                        // duplicate entry -> tie
        default: px = {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                       $urandom_range(1) ? 8'hFF : 8'h00};
      endcase
      return mk_load(pnq_pkg::INDEX_W'($urandom()), px);
    end
    case ($urandom_range(4))
      0, 1: px = pnq_pkg::COLOR_W'($urandom());
      2, 3: px = '{red: nudge(a.red), green: nudge(a.green), blue: nudge(a.blue)};
      default: px = '{red:   8'(({1'b0, a.red} + {1'b0, b.red}) >> 1),
                      green: 8'(({1'b0, a.green} + {1'b0, b.green}) >> 1),
                      blue:  8'(({1'b0, a.blue} + {1'b0, b.blue}) >> 1)};
    endcase
    return mk_pixel(px);
  endfunction

  // Offer one input beat after a gap; returns once it has been accepted.
  task automatic send_beat(quant_beat_t b, int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid       = 1'b1;
    in_if.cmd         = b.cmd;
    in_if.entry_index = b.idx;
    in_if.entry_color = b.color;
    in_if.red_in      = b.px.red;
    in_if.green_in    = b.px.green;
    in_if.blue_in     = b.px.blue;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(b);
  endtask

  // Stop offering and wait for every pending pixel plus the search latency.
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only ever called on an idle block.
  task automatic write_count(logic [pnq_pkg::COUNT_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.count  = value;
    n_settings++;
  endtask

  initial begin
    logic [pnq_pkg::COUNT_W-1:0] set_counts [NUM_SETS];
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.cmd         = pnq_pkg::CMD_LOAD;
    in_if.entry_index = '0;
    in_if.entry_color = '0;
    in_if.red_in      = '0;
    in_if.green_in    = '0;
    in_if.blue_in     = '0;
    rx_free           = 1'b0;
    rx_hold           = 0;
    tx_gapless        = 1'b0;
    n_settings        = 0;
    sb.count          = '0;
    foreach (sb.palette[i]) sb.palette[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty palette passes pixels through unchanged.
    send_beat(mk_pixel(24'h000000), 0);
    send_beat(mk_pixel(24'hFFFFFF), 1);
    // Black, white, primaries, and a second red to set up an exact tie.
    send_beat(mk_load(4'd0, 24'h000000), 0);
    send_beat(mk_load(4'd1, 24'hFFFFFF), 0);
    send_beat(mk_load(4'd2, 24'hFF0000), 2);
    send_beat(mk_load(4'd3, 24'h00FF00), 0);
    send_beat(mk_load(4'd4, 24'h0000FF), 0);
    send_beat(mk_load(4'd5, 24'hFF0000), 0);
    drain();
    write_count(5'd6);
    send_beat(mk_pixel(24'h000000), 0);
    send_beat(mk_pixel(24'hFFFFFF), 0);
    send_beat(mk_pixel(24'h808000), 0);   // equidistant red/green: lower slot wins
    send_beat(mk_pixel(24'hFF0000), 0);   // matches slots 2 and 5
    send_beat(mk_pixel(24'h7F7F7F), 3);   // just nearer black than white
    send_beat(mk_pixel(24'h123456), 0);
    // Fill the rest of the store so every later count only reaches loaded slots.
    for (int i = 6; i < DEPTH; i++)
      send_beat(mk_load(i[pnq_pkg::INDEX_W-1:0], pnq_pkg::COLOR_W'($urandom())), pick_gap());
    drain();

    // Settings: full, single, all-ones (saturates), small, just past depth,
    // empty, one below full, mid, then two random ones.
    set_counts = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd17, 5'd0, 5'd15, 5'd8,
                   5'($urandom_range(31)), 5'($urandom_range(31))};
    for (int s = 0; s < NUM_SETS; s++) begin
      write_count(set_counts[s]);
      tx_gapless = (s == 2);
      rx_free    = (s == 2);
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        // Long back-pressure while the sender keeps offering: the block fills up.
        if (s == 3 && n == 20) rx_hold = LONG_HOLD;
        // Sender pauses until all pending pixels are out.
        if (s == 5 && n == 50) drain();
        send_beat(random_beat(), pick_gap());
      end
      drain();
    end

    $display("tb: %0d pixel beats checked, %0d palette loads, %0d count settings",
             sb.n_checked, sb.n_loads, n_settings);
    $display("tb: %0d mismatching or unexpected results", sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pnq_pkg.sv
rtl/pnq_if.sv
rtl/palette_nearest_color_quantizer.sv
tb/sv/palette_nearest_color_quantizer_tb.sv
